>>> src/crsf_fc_pkg.sv
// Shared constants, codes and the CRC-8 step for the frame checker.
`default_nettype none
package crsf_fc_pkg;

  localparam int unsigned MaxPayload  = 60;
  localparam int unsigned ModeTextMax = 16;

  localparam logic [7:0] CrcPoly = 8'hD5;

  localparam logic [7:0] MinPlenGps      = 8'd15;
  localparam logic [7:0] MinPlenBattery  = 8'd8;
  localparam logic [7:0] MinPlenAttitude = 8'd6;
  localparam logic [7:0] MinPlenLink     = 8'd10;

  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharA   = 8'h41;
  localparam logic [7:0] CharR   = 8'h52;
  localparam logic [7:0] CharM   = 8'h4D;
  localparam logic [7:0] CharS   = 8'h53;
  localparam logic [7:0] CharI   = 8'h49;
  localparam logic [7:0] CharD   = 8'h44;

  typedef enum logic [2:0] {
    StHandled   = 3'd0,
    StPlenShort = 3'd1,
    StUnknown   = 3'd2,
    StBufShort  = 3'd3,
    StBadSync   = 3'd4,
    StBadSize   = 3'd5,
    StTruncated = 3'd6,
    StCrcBad    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    RegSyncA     = 3'd0,
    RegSyncB     = 3'd1,
    RegSyncC     = 3'd2,
    RegGpsType   = 3'd3,
    RegBattType  = 3'd4,
    RegLinkType  = 3'd5,
    RegAttType   = 3'd6,
    RegModeType  = 3'd7
  } reg_idx_e;

  // One byte of CRC-8 DVB-S2, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/crsf_frame_checker_core.sv
// Top level: byte-serial telemetry frame checker with CRC-8 and type classification.
//
// Usage:
//  - Slave stream (s_axis_*): one buffer byte per transaction in tdata, tlast on
//    the final byte of the buffer. Every byte is checked as it arrives: sync code
//    at position 0, size at 1, type at 2, CRC over positions 2..size, and a text
//    scan for the arm state over the first payload bytes of mode frames.
//  - Master stream (m_axis_*): one result transaction per buffer, produced by the
//    byte that carries tlast. Non-final bytes produce nothing.
//  - Config channel (cfg_*): always ready; index selects one of eight 8-bit
//    registers. Write only while no buffer is in flight.
//  - Output: each result is registered; it waits in the skid register on a stall.
//  - Throughput: one byte per cycle while tready is high, set by a single bitwise
//    CRC-8 step plus a few byte compares between the frame state registers.
//  - Stall: a result register plus one skid register decouple the two sides; the
//    slave side drops tready only while both hold a result.
//  - Reset: clears the frame state, the armed flag and the valid flags of both output
//    stages, and loads the registers with their default codes.
`default_nettype none
module crsf_frame_checker_core
  import crsf_fc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [2:0] status, [3] accepted,
                                           // [11:4] msg_type, [17:12] payload_length,
                                           // [18] armed, [23:19] zero
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam logic [8:0] SizeMax     = 9'(MaxPayload + 2);
  localparam logic [7:0] TextMax     = 8'(ModeTextMax);
  localparam logic [7:0] PosSat      = 8'hFF;

  // Configuration registers.
  logic [7:0] sync_a_q, sync_b_q, sync_c_q;
  logic [7:0] gps_q, batt_q, link_q, att_q, mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_a_q <= 8'd200;
      sync_b_q <= 8'd200;
      sync_c_q <= 8'd234;
      gps_q    <= 8'd2;
      batt_q   <= 8'd8;
      link_q   <= 8'd20;
      att_q    <= 8'd30;
      mode_q   <= 8'd33;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegSyncA:    sync_a_q <= cfg_data_i;
        RegSyncB:    sync_b_q <= cfg_data_i;
        RegSyncC:    sync_c_q <= cfg_data_i;
        RegGpsType:  gps_q    <= cfg_data_i;
        RegBattType: batt_q   <= cfg_data_i;
        RegLinkType: link_q   <= cfg_data_i;
        RegAttType:  att_q    <= cfg_data_i;
        RegModeType: mode_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state.
  logic [7:0] pos_q, pos_d;
  logic [7:0] size_q, size_d;
  logic [7:0] type_q, type_d;
  logic [7:0] crc_q, crc_d;
  logic       sync_ok_q, sync_ok_d;
  logic       crc_ok_q, crc_ok_d;
  logic [7:0] win_q [5];
  logic [7:0] win_d [5];
  logic       arm_q, arm_d;
  logic       disarm_q, disarm_d;
  logic       txt_end_q, txt_end_d;
  logic       armed_q, armed_d;

  // Output stages.
  logic        out_valid_q, skid_valid_q;
  logic [23:0] out_data_q, skid_data_q;

  logic       in_acc;
  logic       produce;
  logic [7:0] d;
  logic [7:0] text_lim;
  logic [7:0] plen_full;
  logic       scan_en;
  status_e    status;
  logic [7:0] plen;
  logic [23:0] res_data;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign produce = in_acc && s_axis_tlast;
  assign d       = s_axis_tdata;

  assign plen_full = size_q - 8'd2;
  assign text_lim  = (plen_full > TextMax) ? TextMax : plen_full;
  assign scan_en   = (pos_q >= 8'd3) && (size_q >= 8'd2) && !txt_end_q &&
                     ((pos_q - 8'd3) < text_lim);

  // Advance the frame state by one byte.
  always_comb begin
    pos_d     = pos_q;
    size_d    = size_q;
    type_d    = type_q;
    crc_d     = crc_q;
    sync_ok_d = sync_ok_q;
    crc_ok_d  = crc_ok_q;
    win_d     = win_q;
    arm_d     = arm_q;
    disarm_d  = disarm_q;
    txt_end_d = txt_end_q;
    if (pos_q != PosSat) begin
      if (pos_q == 8'd0) begin
        sync_ok_d = (d == sync_a_q) || (d == sync_b_q) || (d == sync_c_q);
      end else if (pos_q == 8'd1) begin
        size_d = d;
      end else begin
        if (pos_q == 8'd2) begin
          type_d = d;
        end
        if (pos_q <= size_q) begin
          crc_d = crc8_step(crc_q, d);
        end else if ({1'b0, pos_q} == {1'b0, size_q} + 9'd1) begin
          crc_ok_d = (d == crc_q);
        end
        if (scan_en) begin
          if (d == CharNul) begin
            txt_end_d = 1'b1;
          end else begin
            if (d == CharM && win_q[0] == CharR && win_q[1] == CharA) begin
              arm_d = 1'b1;
              if (win_q[2] == CharS && win_q[3] == CharI && win_q[4] == CharD) begin
                disarm_d = 1'b1;
              end
            end
            win_d[4] = win_q[3];
            win_d[3] = win_q[2];
            win_d[2] = win_q[1];
            win_d[1] = win_q[0];
            win_d[0] = d;
          end
        end
      end
      pos_d = pos_q + 8'd1;
    end
  end

  // Classify the buffer from the state after its last byte.
  always_comb begin
    plen    = 8'd0;
    armed_d = armed_q;
    priority if (pos_d < 8'd4) begin
      status = StBufShort;
    end else if (!sync_ok_d) begin
      status = StBadSync;
    end else if (size_d < 8'd2 || {1'b0, size_d} > SizeMax) begin
      status = StBadSize;
    end else if ({1'b0, pos_d} < {1'b0, size_d} + 9'd2) begin
      status = StTruncated;
    end else if (!crc_ok_d) begin
      status = StCrcBad;
    end else begin
      plen = size_d - 8'd2;
      priority if (type_d == gps_q) begin
        status = (plen >= MinPlenGps) ? StHandled : StPlenShort;
      end else if (type_d == batt_q) begin
        status = (plen >= MinPlenBattery) ? StHandled : StPlenShort;
      end else if (type_d == att_q) begin
        status = (plen >= MinPlenAttitude) ? StHandled : StPlenShort;
      end else if (type_d == link_q) begin
        status = (plen >= MinPlenLink) ? StHandled : StPlenShort;
      end else if (type_d == mode_q) begin
        status  = StHandled;
        armed_d = arm_d && !disarm_d;
      end else begin
        status = StUnknown;
      end
    end
  end

  assign res_data = {5'd0, armed_d, plen[5:0], type_d,
                     (status == StHandled) || (status == StPlenShort), status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      size_q    <= '0;
      type_q    <= '0;
      crc_q     <= '0;
      sync_ok_q <= 1'b0;
      crc_ok_q  <= 1'b0;
      win_q     <= '{default: '0};
      arm_q     <= 1'b0;
      disarm_q  <= 1'b0;
      txt_end_q <= 1'b0;
      armed_q   <= 1'b0;
    end else if (produce) begin
      // Drop all per-buffer state; keep only the armed flag.
      pos_q     <= '0;
      size_q    <= '0;
      type_q    <= '0;
      crc_q     <= '0;
      sync_ok_q <= 1'b0;
      crc_ok_q  <= 1'b0;
      win_q     <= '{default: '0};
      arm_q     <= 1'b0;
      disarm_q  <= 1'b0;
      txt_end_q <= 1'b0;
      armed_q   <= armed_d;
    end else if (in_acc) begin
      pos_q     <= pos_d;
      size_q    <= size_d;
      type_q    <= type_d;
      crc_q     <= crc_d;
      sync_ok_q <= sync_ok_d;
      crc_ok_q  <= crc_ok_d;
      win_q     <= win_d;
      arm_q     <= arm_d;
      disarm_q  <= disarm_d;
      txt_end_q <= txt_end_d;
    end
  end

  // Output register and skid register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || produce;
      skid_valid_q <= 1'b0;
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (produce) begin
        out_data_q <= res_data;
      end
    end else if (produce) begin
      skid_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A held skid result always has an occupied output register ahead of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  // The byte counter restarts after every buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> (pos_q == 8'd0))
    else $error("byte position not cleared after last byte");

  // The accepted flag follows the status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[3] == (out_data_q[2:0] == StHandled ||
                                       out_data_q[2:0] == StPlenShort)))
    else $error("accepted flag disagrees with status");

  // A payload length is reported only for buffers that passed all frame checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[2:0] != StHandled && out_data_q[2:0] != StPlenShort &&
     out_data_q[2:0] != StUnknown) |-> (out_data_q[17:12] == 6'd0))
    else $error("payload length reported for rejected buffer");

  // The armed flag moves only on a buffer that ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !produce |=> $stable(armed_q))
    else $error("armed flag changed without a finished buffer");

endmodule
`default_nettype wire
